[hw/rtl/postfix_stack_evaluator_top_defines.svh]
// -----------------------------------------------------------------------------
// postfix_stack_evaluator_top_defines.svh
// Assertion macros used by the evaluator top level.
// -----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pse_pkg.sv]
// -----------------------------------------------------------------------------
// pse_pkg
// Types, constants and codes shared by the postfix stack evaluator.
// -----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;

  localparam int CMD_W    = 3;
  localparam int NUM_W    = 31;
  localparam int RES_W    = 32;
  localparam int STATUS_W = 2;

  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W    = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W = $clog2(DATA_WIDTH);

  // token commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } pse_err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_FIN_RD,
    S_FIN_OUT
  } pse_state_t;

  // controller -> datapath
  typedef struct packed {
    logic tok_load;
    logic pop_b;
    logic pop_a;
    logic exec;
    logic div_start;
    logic push;
    logic finish;
  } pse_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             last;
    logic             err_divz;
    logic             b_zero;
    logic             div_done;
    logic             div_busy;
    logic             empty;
  } pse_stat_t;

endpackage

[hw/rtl/pse_div.sv]
// -----------------------------------------------------------------------------
// pse_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// -----------------------------------------------------------------------------
module pse_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pse_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [pse_pkg::DATA_WIDTH-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [pse_pkg::DATA_WIDTH-1:0] quotient
);

  localparam int DW = pse_pkg::DATA_WIDTH;

  logic                           busy_r;
  logic                           done_r;
  logic [pse_pkg::DIV_CNT_W-1:0]  step_r;
  logic [DW-1:0]                  rem_r;
  logic [DW-1:0]                  quo_r;
  logic [DW-1:0]                  den_r;
  logic                           neg_r;

  logic [DW-1:0]                  mag_a;
  logic [DW-1:0]                  mag_b;
  logic [DW:0]                    rem_sh;
  logic [DW:0]                    diff;
  logic                           ge;
  logic [DW-1:0]                  rem_nxt;

  assign mag_a = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[DW-1]  ? (~divisor + 1'b1)  : divisor;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign diff    = rem_sh - {1'b0, den_r};
  assign ge      = ~diff[DW];
  assign rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= pse_pkg::DIV_CNT_W'(DW - 1);
      rem_r  <= '0;
      quo_r  <= mag_a;
      den_r  <= mag_b;
      neg_r  <= dividend[DW-1] ^ divisor[DW-1];
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[DW-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

[hw/rtl/pse_dpath.sv]
// -----------------------------------------------------------------------------
// pse_dpath
// Evaluator datapath: token registers, stack memory, operand and result
// registers, divider and output register.
// -----------------------------------------------------------------------------
module pse_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pse_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pse_pkg::NUM_W-1:0]     in_number,
  input  logic                          in_last_token,
  input  pse_pkg::pse_ctl_t             ctl,
  output pse_pkg::pse_stat_t            stat,
  output logic signed [pse_pkg::RES_W-1:0] out_result_value,
  output logic [pse_pkg::STATUS_W-1:0]  out_status
);

  localparam int DW = pse_pkg::DATA_WIDTH;

  logic [DW-1:0] stack_mem [pse_pkg::STACK_DEPTH];

  logic [pse_pkg::CMD_W-1:0]    tok_cmd_r;
  logic [pse_pkg::NUM_W-1:0]    tok_num_r;
  logic                         tok_last_r;
  logic [pse_pkg::CNT_W-1:0]    cnt_r;
  logic [pse_pkg::CNT_W-1:0]    cnt_nxt;
  pse_pkg::pse_err_t            err_r;
  pse_pkg::pse_err_t            err_nxt;
  logic [DW-1:0]                a_r;
  logic [DW-1:0]                b_r;
  logic [DW-1:0]                res_r;
  logic [DW-1:0]                rd_data_r;
  logic signed [pse_pkg::RES_W-1:0] out_val_r;
  logic [pse_pkg::STATUS_W-1:0] out_status_r;

  logic                         empty;
  logic                         mem_we;
  logic [DW-1:0]                push_val;
  logic [DW-1:0]                pop_val;
  logic [63:0]                  num64;
  logic signed [63:0]           pop64;
  logic [pse_pkg::CNT_W-1:0]    cnt_dec;
  logic [pse_pkg::ADDR_W-1:0]   rd_addr;
  logic                         div_busy;
  logic                         div_done;
  logic [DW-1:0]                div_q;

  assign empty    = (cnt_r == '0);
  assign num64    = 64'(tok_num_r);
  assign push_val = (tok_cmd_r == pse_pkg::CMD_PUSH) ? num64[DW-1:0] : res_r;
  // empty stack pops as all ones
  assign pop_val  = empty ? '1 : rd_data_r;
  assign pop64    = 64'(signed'(pop_val));

  always_comb begin
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    mem_we  = 1'b0;
    if (ctl.pop_b || ctl.pop_a) begin
      if (empty) begin
        if (err_r == pse_pkg::ERR_NONE) err_nxt = pse_pkg::ERR_UNDER;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
    // divide by zero overrides any earlier error
    if (ctl.exec && (tok_cmd_r == pse_pkg::CMD_DIV) && (b_r == '0)) begin
      err_nxt = pse_pkg::ERR_DIVZ;
    end
    if (ctl.push) begin
      if (cnt_r < pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end else if (err_r == pse_pkg::ERR_NONE) begin
        err_nxt = pse_pkg::ERR_OVER;
      end
    end
    if (ctl.finish) begin
      cnt_nxt = '0;
      err_nxt = pse_pkg::ERR_NONE;
    end
  end

  // read ahead the entry that will be on top next cycle
  assign cnt_dec = cnt_nxt - 1'b1;
  assign rd_addr = (cnt_nxt == '0) ? '0 : cnt_dec[pse_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[cnt_r[pse_pkg::ADDR_W-1:0]] <= push_val;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= pse_pkg::ERR_NONE;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tok_load) begin
      tok_cmd_r  <= in_cmd;
      tok_num_r  <= in_number;
      tok_last_r <= in_last_token;
    end
    if (ctl.pop_b) b_r <= pop_val;
    if (ctl.pop_a) a_r <= pop_val;
    if (ctl.exec) begin
      case (tok_cmd_r)
        pse_pkg::CMD_ADD: res_r <= a_r + b_r;
        pse_pkg::CMD_SUB: res_r <= a_r - b_r;
        pse_pkg::CMD_MUL: res_r <= a_r * b_r;
        default:          res_r <= res_r;
      endcase
    end else if (div_done) begin
      res_r <= div_q;
    end
    if (ctl.finish) begin
      out_val_r    <= (err_r == pse_pkg::ERR_DIVZ) ? '0 : pop64[pse_pkg::RES_W-1:0];
      out_status_r <= (err_r == pse_pkg::ERR_NONE && empty) ? pse_pkg::ERR_UNDER : err_r;
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.cmd      = tok_cmd_r;
  assign stat.last     = tok_last_r;
  assign stat.err_divz = (err_r == pse_pkg::ERR_DIVZ);
  assign stat.b_zero   = (b_r == '0);
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;
  assign stat.empty    = empty;

  assign out_result_value = out_val_r;
  assign out_status       = out_status_r;

endmodule

[hw/rtl/pse_ctrl.sv]
// -----------------------------------------------------------------------------
// pse_ctrl
// Evaluator controller: sequences pops, execute, divide, push and the
// end-of-expression result, and owns the output valid.
// -----------------------------------------------------------------------------
module pse_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [pse_pkg::CMD_W-1:0] in_cmd,
  input  logic                      in_last_token,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  pse_pkg::pse_stat_t        stat,
  output pse_pkg::pse_ctl_t         ctl
);

  pse_pkg::pse_state_t state_r;
  pse_pkg::pse_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pse_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl           = '0;
    in_stall      = (state_r != pse_pkg::S_IDLE);
    unique case (state_r)
      pse_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.tok_load = 1'b1;
          if (stat.err_divz) begin
            // skip the rest of the expression
            state_nxt = in_last_token ? pse_pkg::S_FIN_RD : pse_pkg::S_IDLE;
          end else begin
            case (in_cmd) inside
              pse_pkg::CMD_PUSH: state_nxt = pse_pkg::S_PUSH;
              pse_pkg::CMD_ADD, pse_pkg::CMD_SUB, pse_pkg::CMD_MUL, pse_pkg::CMD_DIV:
                state_nxt = pse_pkg::S_POP_B;
              default:
                state_nxt = in_last_token ? pse_pkg::S_FIN_RD : pse_pkg::S_IDLE;
            endcase
          end
        end
      end
      pse_pkg::S_POP_B: begin
        ctl.pop_b = 1'b1;
        state_nxt = pse_pkg::S_POP_A;
      end
      pse_pkg::S_POP_A: begin
        ctl.pop_a = 1'b1;
        state_nxt = pse_pkg::S_EXEC;
      end
      pse_pkg::S_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.cmd == pse_pkg::CMD_DIV) begin
          if (stat.b_zero) begin
            state_nxt = stat.last ? pse_pkg::S_FIN_RD : pse_pkg::S_IDLE;
          end else begin
            ctl.div_start = 1'b1;
            state_nxt     = pse_pkg::S_DIV;
          end
        end else begin
          state_nxt = pse_pkg::S_PUSH;
        end
      end
      pse_pkg::S_DIV: begin
        if (stat.div_done) state_nxt = pse_pkg::S_PUSH;
      end
      pse_pkg::S_PUSH: begin
        ctl.push  = 1'b1;
        state_nxt = stat.last ? pse_pkg::S_FIN_RD : pse_pkg::S_IDLE;
      end
      pse_pkg::S_FIN_RD: begin
        // let the top-of-stack read settle after a push
        state_nxt = pse_pkg::S_FIN_OUT;
      end
      pse_pkg::S_FIN_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          ctl.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pse_pkg::S_IDLE;
        end
      end
      default: state_nxt = pse_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/postfix_stack_evaluator_top.sv]
// -----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix integer expression evaluator on a bounded stack.
//
//   Channel  Ports                                     Handshake
//   input    in_cmd, in_number, in_last_token          in_valid / in_stall
//   output   out_result_value, out_status              out_valid / out_stall
//
// Number push: the push state. Add, subtract, multiply: pop, pop, execute,
// push. Divide: pop, pop, execute, then wait until the one-bit-per-cycle
// divider is done, then push. A last token adds top-of-stack read and output.
// One transaction is in work at a time; a new one is taken while a result
// still waits in the output register. rst_n is synchronous; it clears the
// stack count, the error and the control state, the stack memory is not
// cleared. A stalled output holds the block only when a next result is due.
// -----------------------------------------------------------------------------
`include "postfix_stack_evaluator_top_defines.svh"

module postfix_stack_evaluator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pse_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pse_pkg::NUM_W-1:0]        in_number,
  input  logic                             in_last_token,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pse_pkg::RES_W-1:0] out_result_value,
  output logic [pse_pkg::STATUS_W-1:0]     out_status
);

  pse_pkg::pse_ctl_t  ctl;
  pse_pkg::pse_stat_t stat;
  logic               tok_work;

  pse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_cmd        (in_cmd),
    .in_last_token (in_last_token),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stat          (stat),
    .ctl           (ctl)
  );

  pse_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_number        (in_number),
    .in_last_token    (in_last_token),
    .ctl              (ctl),
    .stat             (stat),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  // accepted push or operator that is not skipped after a divide by zero
  assign tok_work = in_valid && !in_stall && !stat.err_divz &&
                    (in_cmd <= pse_pkg::CMD_DIV);

  `PSE_ASSERT_NEXT(a_accept_then_busy, tok_work, in_stall, "accepted token not held off")
  `PSE_ASSERT_SAME(a_div_start_idle, ctl.div_start, !stat.div_busy, "divider restarted while busy")
  `PSE_ASSERT_SAME(a_finish_out_free, ctl.finish, !out_valid || !out_stall, "result overwrote pending output")
  `PSE_ASSERT_NEXT(a_finish_clears, ctl.finish, stat.empty && out_valid, "stack not cleared after result")

endmodule
